[rtl/mbfc_pkg.sv]
package mbfc_pkg;

  // CRC-16 as used on the serial line: reflected, polynomial 0xA001, preset 0xFFFF.
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] CRC_PRESET = 16'hFFFF;

  // Frame length limits. The byte count saturates at the top of its nine bits.
  localparam int          MAX_FRAME_DEF = 256;
  localparam logic [8:0]  LEN_SAT       = 9'h1FF;
  localparam logic [8:0]  MIN_FRAME     = 9'd4;

  // Reset value of the slave address register.
  localparam logic [7:0]  DEV_ADDR_RST  = 8'h01;
  localparam logic [7:0]  BCAST_ADDR    = 8'h00;

  // Supported function codes.
  localparam logic [7:0]  FC_READ_COILS  = 8'd1;
  localparam logic [7:0]  FC_READ_INPUTS = 8'd2;
  localparam logic [7:0]  FC_WRITE_COIL  = 8'd5;
  localparam logic [7:0]  FC_WRITE_COILS = 8'd15;

  // Exception reply: error flag on the function code and the illegal-function code.
  localparam logic [7:0]  EXC_FLAG         = 8'h80;
  localparam logic [7:0]  EXC_ILLEGAL_FUNC = 8'h01;

  // Beats of the exception reply.
  localparam logic [2:0]  BEAT_ADDR    = 3'd0;
  localparam logic [2:0]  BEAT_FUNC    = 3'd1;
  localparam logic [2:0]  BEAT_CODE    = 3'd2;
  localparam logic [2:0]  BEAT_CRC_LO  = 3'd3;
  localparam logic [2:0]  BEAT_CRC_HI  = 3'd4;

  // Verdict on a received frame.
  typedef enum logic [1:0] {
    KIND_DROP_ADDR = 2'd0,
    KIND_DROP_CRC  = 2'd1,
    KIND_REQUEST   = 2'd2,
    KIND_EXCEPTION = 2'd3
  } kind_t;

  // Frame descriptor passed from the receive side to the reply side.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] func;
    logic       bcast;
    logic [8:0] len;
    logic [7:0] addr;
  } desc_t;

  // Fold one byte into the reflected CRC, one bit per step.
  function automatic logic [15:0] crc_fold(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/mbfc_if.sv]
// Received byte channel.
interface mbfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

// Result channel.
interface mbfc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] function_code;
  logic       broadcast;
  logic [8:0] frame_length;
  logic [7:0] tx_byte;
  logic       last;

  modport source (output valid, output kind, output function_code, output broadcast,
                  output frame_length, output tx_byte, output last, input ready);
  modport sink   (input valid, input kind, input function_code, input broadcast,
                  input frame_length, input tx_byte, input last, output ready);
endinterface

// Slave address write channel.
interface mbfc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] device_address;

  modport source (output valid, output device_address, input ready);
  modport sink   (input valid, input device_address, output ready);
endinterface

[rtl/mbfc_front.sv]
module mbfc_front
  import mbfc_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  mbfc_in_if.sink      in_ch,
  mbfc_cfg_if.sink     cfg_ch,
  input  logic         q_full,
  output logic         q_push,
  output desc_t        q_desc
);

  logic [7:0]  dev_addr_r;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  held0_r, held0_nxt;
  logic [7:0]  held1_r, held1_nxt;
  logic [8:0]  count_r, count_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  func_r, func_nxt;
  logic        ovf_r, ovf_nxt;
  logic        in_fire;
  logic        end_fire;
  logic        func_ok;

  // A frame end needs a free queue slot, so bytes are taken whenever one is free.
  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign end_fire     = in_fire && in_ch.frame_end;

  // Slave address register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      dev_addr_r <= cfg_ch.device_address;
    end
  end

  // Frame state after taking in the current byte. The CRC trails by two bytes
  // so that the received checksum is never folded in.
  always_comb begin
    ovf_nxt   = ovf_r || (int'(count_r) >= MAX_FRAME) || (count_r == LEN_SAT);
    addr_nxt  = (count_r == 9'd0) ? in_ch.rx_byte : addr_r;
    func_nxt  = (count_r == 9'd1) ? in_ch.rx_byte : func_r;
    crc_nxt   = (count_r >= 9'd2) ? crc_fold(crc_r, held0_r) : crc_r;
    held0_nxt = held1_r;
    held1_nxt = in_ch.rx_byte;
    count_nxt = (count_r != LEN_SAT) ? count_r + 9'd1 : count_r;
  end

  // Classify the frame at its last byte: length, then address, then CRC, then code.
  assign func_ok = (func_nxt == FC_READ_COILS) || (func_nxt == FC_READ_INPUTS) ||
                   (func_nxt == FC_WRITE_COIL) || (func_nxt == FC_WRITE_COILS);

  always_comb begin
    q_push       = end_fire;
    q_desc.func  = func_nxt;
    q_desc.bcast = (addr_nxt == BCAST_ADDR);
    q_desc.len   = count_nxt;
    q_desc.addr  = addr_nxt;
    if (ovf_nxt || (count_nxt < MIN_FRAME)) begin
      q_desc.kind = KIND_DROP_CRC;
    end else if ((addr_nxt != dev_addr_r) && (addr_nxt != BCAST_ADDR)) begin
      q_desc.kind = KIND_DROP_ADDR;
    end else if ((held0_nxt != crc_nxt[7:0]) || (held1_nxt != crc_nxt[15:8])) begin
      q_desc.kind = KIND_DROP_CRC;
    end else if (func_ok) begin
      q_desc.kind = KIND_REQUEST;
    end else begin
      q_desc.kind = KIND_EXCEPTION;
    end
  end

  // Frame registers: advance on each byte and return to reset after the last one.
  always_ff @(posedge clk) begin
    if (!rst_n || end_fire) begin
      crc_r   <= CRC_PRESET;
      held0_r <= 8'h00;
      held1_r <= 8'h00;
      count_r <= 9'd0;
      addr_r  <= 8'h00;
      func_r  <= 8'h00;
      ovf_r   <= 1'b0;
    end else if (in_fire) begin
      crc_r   <= crc_nxt;
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
      count_r <= count_nxt;
      addr_r  <= addr_nxt;
      func_r  <= func_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // A frame end always finds room in the queue and leaves the frame state cleared.
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("frame end accepted with a full queue");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    end_fire |=> (count_r == 9'd0) && (crc_r == CRC_PRESET) && !ovf_r)
    else $error("frame state not cleared after frame end");

endmodule

[rtl/mbfc_queue.sv]
module mbfc_queue
  import mbfc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  output logic  full,
  input  logic  pop,
  output desc_t head,
  output logic  empty
);

  desc_t       ent_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  fill_r;
  logic        do_push;
  logic        do_pop;

  assign full    = (fill_r == 2'd2);
  assign empty   = (fill_r == 2'd0);
  assign head    = ent_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Descriptor storage, no reset needed.
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_desc;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

  // The fill level always agrees with the pointer distance.
  a_fill_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == 2'd1) == (wr_ptr_r != rd_ptr_r))
    else $error("queue fill level disagrees with pointers");

endmodule

[rtl/mbfc_back.sv]
module mbfc_back
  import mbfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  desc_t      q_head,
  output logic       q_pop,
  mbfc_out_if.source out_ch
);

  desc_t       desc_r;
  logic        busy_r;
  logic [2:0]  beat_r;
  logic [15:0] crc_r;
  logic        out_fire;
  logic        last_beat;
  logic [7:0]  tx_byte;

  // A verdict is one transaction; an exception reply is five.
  assign last_beat = (desc_r.kind != KIND_EXCEPTION) || (beat_r == BEAT_CRC_HI);
  assign out_fire  = out_ch.valid && out_ch.ready;
  assign q_pop     = !q_empty && (!busy_r || (out_fire && last_beat));

  // Exception reply bytes; the CRC register has taken in the first three by the fourth.
  always_comb begin
    tx_byte = 8'h00;
    if (desc_r.kind == KIND_EXCEPTION) begin
      case (beat_r)
        BEAT_ADDR:   tx_byte = desc_r.addr;
        BEAT_FUNC:   tx_byte = desc_r.func | EXC_FLAG;
        BEAT_CODE:   tx_byte = EXC_ILLEGAL_FUNC;
        BEAT_CRC_LO: tx_byte = crc_r[7:0];
        BEAT_CRC_HI: tx_byte = crc_r[15:8];
        default:     tx_byte = 8'h00;
      endcase
    end
  end

  assign out_ch.valid         = busy_r;
  assign out_ch.kind          = desc_r.kind;
  assign out_ch.function_code = desc_r.func;
  assign out_ch.broadcast     = desc_r.bcast;
  assign out_ch.frame_length  = desc_r.len;
  assign out_ch.tx_byte       = tx_byte;
  assign out_ch.last          = last_beat;

  // Current descriptor, held until its last transaction is taken.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      desc_r <= q_head;
    end
  end

  // Beat counter and running CRC of the exception reply.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      beat_r <= BEAT_ADDR;
      crc_r  <= CRC_PRESET;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      beat_r <= BEAT_ADDR;
      crc_r  <= CRC_PRESET;
    end else if (out_fire) begin
      if (last_beat) begin
        busy_r <= 1'b0;
      end else begin
        beat_r <= beat_r + 3'd1;
      end
      if (beat_r < BEAT_CRC_LO) begin
        crc_r <= crc_fold(crc_r, tx_byte);
      end
    end
  end

  // Only exception replies run past their first transaction.
  a_multi_is_exc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last) |-> (desc_r.kind == KIND_EXCEPTION))
    else $error("multi-transaction result that is not an exception");

  // After a non-final transaction the reply continues with the next beat.
  a_reply_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !last_beat) |=> busy_r && (beat_r == $past(beat_r) + 3'd1))
    else $error("exception reply broken off");

endmodule

[rtl/modbus_rtu_frame_check_core.sv]
// Frame checker for a serial-line slave. Received bytes enter one per transaction on in_ch,
// the final byte of each frame flagged by frame_end. Every byte but the trailing two is
// folded into a CRC-16 (reflected, 0xA001, preset 0xFFFF), and nothing appears on out_ch
// until a frame ends. At the frame end one verdict transaction is produced: dropped for
// length (under four bytes or over MAX_FRAME), for address or for CRC, or an accepted
// request for function codes 1, 2, 5 and 15. Other codes yield a five-transaction
// illegal-function exception reply (address, code with the error flag, 0x01, CRC low, CRC
// high) at one transaction per cycle while out_ch is ready; its CRC is built one byte per
// beat. A two-entry queue between the receive and reply sides absorbs back-pressure; in_ch
// takes a byte every cycle unless that queue is full. The slave address (reset to 1) is to
// be written through cfg_ch while no frame is in flight; the block does not enforce this.
module modbus_rtu_frame_check_core
  import mbfc_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mbfc_in_if.sink    in_ch,
  mbfc_out_if.source out_ch,
  mbfc_cfg_if.sink   cfg_ch
);

  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  desc_t q_in;
  desc_t q_head;

  // Receive side: CRC, frame registers and classification.
  mbfc_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_desc (q_in)
  );

  // Descriptor queue between the two sides.
  mbfc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // Reply side: verdicts and exception frames.
  mbfc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

[tb/modbus_rtu_frame_check_core_test.sv]
module modbus_rtu_frame_check_core_test;
  import mbfc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 20;

  // One expected transaction on the result channel.
  typedef struct {
    kind_t      kind;
    logic [7:0] func;
    logic       bcast;
    logic [8:0] len;
    logic [7:0] tx;
    logic       last;
  } verdict_t;

  logic clk;
  logic rst_n;

  mbfc_in_if  in_ch ();
  mbfc_out_if out_ch ();
  mbfc_cfg_if cfg_ch ();

  modbus_rtu_frame_check_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Mirror of the frame checker: slave address and the frame being received.
  logic [7:0]  slave_addr = DEV_ADDR_RST;
  logic [15:0] frame_crc  = CRC_PRESET;
  logic [7:0]  tail_bytes [0:1] = '{8'h00, 8'h00};
  logic [8:0]  rx_count   = '0;
  logic [7:0]  addr_seen  = '0;
  logic [7:0]  func_seen  = '0;
  logic        too_long   = 1'b0;

  verdict_t pending_verdicts[$];

  int send_gap_pct = 0;
  int take_gap_pct = 0;
  int stall_left   = 0;
  int mismatches   = 0;
  int bytes_taken  = 0;
  int frames_seen  = 0;
  int verdicts_ok  = 0;

  // Free-running clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Bit-serial reflected CRC-16, one data bit tested against the low bit per step.
  function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      if (r[0] ^ data[k]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic void clear_frame();
    frame_crc     = CRC_PRESET;
    tail_bytes[0] = 8'h00;
    tail_bytes[1] = 8'h00;
    rx_count      = '0;
    addr_seen     = '0;
    func_seen     = '0;
    too_long      = 1'b0;
  endfunction

  // Fold one received byte into the frame and queue the verdicts it causes.
  function automatic void predict_byte(input logic [7:0] b, input logic fe);
    verdict_t   v;
    logic [7:0] reply [0:4];
    logic [15:0] c;
    if (rx_count >= MAX_FRAME_DEF || rx_count >= LEN_SAT) too_long = 1'b1;
    if (rx_count == 0) begin
      addr_seen = b;
    end else if (rx_count == 1) begin
      func_seen = b;
    end
    if (rx_count >= 2) frame_crc = crc16_update(frame_crc, tail_bytes[0]);
    tail_bytes[0] = tail_bytes[1];
    tail_bytes[1] = b;
    if (rx_count < LEN_SAT) rx_count++;
    if (!fe) return;

    v.func  = func_seen;
    v.bcast = (addr_seen == BCAST_ADDR);
    v.len   = rx_count;
    v.tx    = 8'h00;
    v.last  = 1'b1;
    if (too_long || rx_count < MIN_FRAME) begin
      v.kind = KIND_DROP_CRC;
      pending_verdicts.push_back(v);
    end else if (addr_seen != slave_addr && addr_seen != BCAST_ADDR) begin
      v.kind = KIND_DROP_ADDR;
      pending_verdicts.push_back(v);
    end else if (tail_bytes[0] != frame_crc[7:0] || tail_bytes[1] != frame_crc[15:8]) begin
      v.kind = KIND_DROP_CRC;
      pending_verdicts.push_back(v);
    end else if (func_seen inside {FC_READ_COILS, FC_READ_INPUTS, FC_WRITE_COIL,
                                   FC_WRITE_COILS}) begin
      v.kind = KIND_REQUEST;
      pending_verdicts.push_back(v);
    end else begin
      // Illegal-function reply, one transaction per byte, CRC appended low byte first.
      reply[0] = addr_seen;
      reply[1] = func_seen | EXC_FLAG;
      reply[2] = EXC_ILLEGAL_FUNC;
      c = crc16_update(CRC_PRESET, reply[0]);
      c = crc16_update(c, reply[1]);
      c = crc16_update(c, reply[2]);
      reply[3] = c[7:0];
      reply[4] = c[15:8];
      v.kind = KIND_EXCEPTION;
      for (int i = 0; i < 5; i++) begin
        v.tx   = reply[i];
        v.last = (i == 4);
        pending_verdicts.push_back(v);
      end
    end
    clear_frame();
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns mismatch: %s", $time, what);
  endtask

  // Compare one result transaction with the oldest expected verdict.
  task automatic check_verdict();
    verdict_t want;
    if (pending_verdicts.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d tx %02h",
                                out_ch.kind, out_ch.tx_byte));
      return;
    end
    want = pending_verdicts.pop_front();
    if (out_ch.kind !== want.kind)
      report_mismatch($sformatf("kind %0d, wanted %0d", out_ch.kind, want.kind));
    if (out_ch.function_code !== want.func)
      report_mismatch($sformatf("function_code %02h, wanted %02h", out_ch.function_code,
                                want.func));
    if (out_ch.broadcast !== want.bcast)
      report_mismatch($sformatf("broadcast %0b, wanted %0b", out_ch.broadcast, want.bcast));
    if (out_ch.frame_length !== want.len)
      report_mismatch($sformatf("frame_length %0d, wanted %0d", out_ch.frame_length,
                                want.len));
    if (out_ch.tx_byte !== want.tx)
      report_mismatch($sformatf("tx_byte %02h, wanted %02h", out_ch.tx_byte, want.tx));
    if (out_ch.last !== want.last)
      report_mismatch($sformatf("last %0b, wanted %0b", out_ch.last, want.last));
    verdicts_ok++;
  endtask

  // Watch all three channels at each edge: received bytes, then address writes, then results.
  // A byte taken at the same edge as an address write still sees the old address.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        bytes_taken++;
        if (in_ch.frame_end) frames_seen++;
        predict_byte(in_ch.rx_byte, in_ch.frame_end);
      end
      if (cfg_ch.valid && cfg_ch.ready) slave_addr = cfg_ch.device_address;
      if (out_ch.valid && out_ch.ready) check_verdict();
    end
  end

  // Result receiver: random gaps, or a long hold-off while a stall is requested.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= take_gap_pct);
    end
  end

  // Offer one byte, with random gaps beforehand; valid stays high for a following byte.
  task automatic send_byte(input logic [7:0] b, input logic fe);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.rx_byte   <= b;
    in_ch.frame_end <= fe;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_bytes(input logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  // Build a frame with its CRC; a bad frame has one bit of the CRC flipped.
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] func,
                            input int data_len, input bit bad_crc);
    logic [7:0]  q[$];
    logic [15:0] c;
    int          pos;
    q = {addr, func};
    repeat (data_len) q.push_back(8'($urandom));
    c = CRC_PRESET;
    foreach (q[i]) c = crc16_update(c, q[i]);
    q.push_back(c[7:0]);
    q.push_back(c[15:8]);
    if (bad_crc) begin
      pos = q.size() - 1 - $urandom_range(1);
      q[pos][$urandom_range(7)] ^= 1'b1;
    end
    send_bytes(q);
  endtask

  task automatic send_noise(input int n);
    logic [7:0] q[$];
    repeat (n) q.push_back(8'($urandom));
    send_bytes(q);
  endtask

  // Mostly our own address, often broadcast, sometimes anything.
  function automatic logic [7:0] pick_address();
    int p;
    p = $urandom_range(99);
    if (p < 60) return slave_addr;
    if (p < 80) return BCAST_ADDR;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_function();
    if ($urandom_range(99) < 30) return 8'($urandom);
    case ($urandom_range(3))
      0: return FC_READ_COILS;
      1: return FC_READ_INPUTS;
      2: return FC_WRITE_COIL;
      default: return FC_WRITE_COILS;
    endcase
  endfunction

  // Stop offering bytes and wait until every expected verdict has come out.
  task automatic wait_for_verdicts();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_address(input logic [7:0] a);
    wait_for_verdicts();
    cfg_ch.valid          <= 1'b1;
    cfg_ch.device_address <= a;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Short frames, every verdict, broadcast exception and the extreme function codes.
  task automatic test_directed();
    logic [7:0] q[$];
    q = {8'hFF};
    send_bytes(q);
    q = {8'h01, FC_READ_COILS, 8'h00};
    send_bytes(q);
    send_frame(slave_addr, FC_READ_COILS, 0, 1'b0);
    send_frame(8'hFF, FC_WRITE_COIL, 0, 1'b0);
    send_frame(slave_addr, FC_WRITE_COILS, 0, 1'b1);
    send_frame(BCAST_ADDR, 8'hFF, 0, 1'b0);
    send_frame(slave_addr, 8'h00, 0, 1'b0);
  endtask

  // Mostly well-formed frames with random content, the rest noise and broken frames.
  task automatic test_random_traffic(input int budget);
    int sent;
    int p;
    int n;
    sent = 0;
    while (sent < budget) begin
      p = $urandom_range(99);
      if (p < 80) begin
        n = $urandom_range(8);
        send_frame(pick_address(), pick_function(), n, $urandom_range(99) < 10);
        sent += n + 4;
      end else if (p < 90) begin
        n = $urandom_range(1, 3);
        send_noise(n);
        sent += n;
      end else begin
        n = $urandom_range(4, 10);
        send_noise(n);
        sent += n;
      end
    end
  endtask

  // A well-formed frame one byte over the length limit must still be dropped.
  task automatic test_long_frames();
    send_frame(slave_addr, FC_READ_COILS, MAX_FRAME_DEF - 3, 1'b0);
  endtask

  // Hold the receiver off while exception frames keep coming, so the input must stall.
  task automatic test_receiver_stall();
    stall_left = 300;
    repeat (8) send_frame(slave_addr, 8'($urandom_range(16, 127)), 0, 1'b0);
  endtask

  // Run limit.
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [7:0] mid_addr;
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.rx_byte         = 8'h00;
    in_ch.frame_end       = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.device_address = 8'h00;
    out_ch.ready          = 1'b0;
    mid_addr              = 8'($urandom_range(2, 246));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_gap_pct = 12;
    take_gap_pct = 59;
    test_directed();
    test_random_traffic(33);

    write_address(8'd247);
    send_gap_pct = 59;
    take_gap_pct = 12;
    test_random_traffic(32);

    write_address(8'd1);
    write_address(mid_addr);
    send_gap_pct = 0;
    take_gap_pct = 0;
    test_random_traffic(32);
    test_long_frames();
    test_receiver_stall();

    wait_for_verdicts();
    $display("Covered %0d received bytes in %0d frames; %0d results were compared.",
             bytes_taken, frames_seen, verdicts_ok);
    $display("Slave addresses 1, 247 and %0d, a frame over the length limit, long stall.",
             mid_addr);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
